FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Plain condition checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("condition violated");

`endif

FILE: hdl/chxy_pkg.sv
// ----------------------------------------------------------------------------
// chxy_pkg
// Types, widths and the arctangent table for the compass heading pipeline.
// ----------------------------------------------------------------------------
package chxy_pkg;

    localparam int IN_W       = 16;   // magnetometer axis width
    localparam int DEG_W      = 9;    // heading width, 0..359
    localparam int S_DATA_W   = 32;   // x and y packed
    localparam int M_DATA_W   = 16;   // heading padded to whole bytes
    localparam int FRAC_BITS  = 16;   // fraction bits of a degree
    localparam int COMP_W     = 19;   // vector components incl. CORDIC gain
    localparam int ANGLE_W    = 25;   // accumulated angle, signed Q16 degrees
    localparam int HEAD_W     = 26;   // heading before clamp, signed Q16
    localparam int ATAN_W     = 22;   // table entry width
    localparam int ATAN_TABLE_LEN = 24;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [ATAN_TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    localparam logic signed [HEAD_W-1:0] DEG90_Q16  = HEAD_W'(90  << FRAC_BITS);
    localparam logic signed [HEAD_W-1:0] DEG180_Q16 = HEAD_W'(180 << FRAC_BITS);
    localparam logic signed [HEAD_W-1:0] DEG270_Q16 = HEAD_W'(270 << FRAC_BITS);
    localparam logic signed [HEAD_W-1:0] DEG360_Q16 = HEAD_W'(360 << FRAC_BITS);
    localparam logic [DEG_W-1:0]         DEG_MAX    = DEG_W'(359);

    // which formula the heading takes, chosen from the signs of x and y
    typedef enum logic [1:0] {
        QUAD_Y_POS,
        QUAD_Y_NEG,
        QUAD_AXIS_NEG_X,
        QUAD_AXIS_POS_X
    } quad_t;

endpackage

FILE: hdl/compass_heading_from_xy_top.sv
// ----------------------------------------------------------------------------
// compass_heading_from_xy_top
// Fully pipelined CORDIC compass: magnetometer X/Y word in, heading word out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one word per sample, x in s_tdata[15:0], y in
//   s_tdata[31:16], both two's complement.
//   Output channel m_*: one word per sample, heading in m_tdata[8:0],
//   whole degrees 0..359 truncated toward zero; upper bits are zero.
//   Throughput: one word per cycle while the output is not stalled. The CORDIC
//   is unrolled, one register stage per iteration, so a new sample can enter
//   every cycle unless m_tready holds the output. Path from input accept to
//   m_tvalid: one prepare stage, one stage per iteration, one output stage.
//   Stall: the whole pipeline advances on one enable, held while the output
//   word waits on m_tready; s_tready drops with it, nothing is lost or
//   repeated. Samples keep entering while earlier ones are in flight.
//   Reset: aresetn (synchronous, active low) clears all valid bits; the
//   pipeline is empty and ready in the first cycle after reset.
//   Results are one per sample, in input order.
// ----------------------------------------------------------------------------
module compass_heading_from_xy_top #(
    parameter int ANGLE_ITERATIONS = 16     // CORDIC iterations, 12..24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: [15:0] field_x, [31:16] field_y
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [chxy_pkg::S_DATA_W-1:0]    s_tdata,
    // m_tdata: [8:0] heading_deg, [15:9] zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [chxy_pkg::M_DATA_W-1:0]    m_tdata
);
    import chxy_pkg::*;

    localparam int STAGES = (ANGLE_ITERATIONS < ATAN_TABLE_LEN) ?
                            ANGLE_ITERATIONS : ATAN_TABLE_LEN;

    // pipeline registers; index 0 is the prepare stage, k is after k iterations
    logic                      valid_reg [0:STAGES];
    logic signed [COMP_W-1:0]  x_reg     [0:STAGES];
    logic signed [COMP_W-1:0]  y_reg     [0:STAGES];
    logic signed [ANGLE_W-1:0] z_reg     [0:STAGES];
    quad_t                     quad_reg  [0:STAGES];

    logic signed [COMP_W-1:0]  x_next    [0:STAGES];
    logic signed [COMP_W-1:0]  y_next    [0:STAGES];
    logic signed [ANGLE_W-1:0] z_next    [0:STAGES];
    quad_t                     quad_next [0:STAGES];

    logic                      m_valid_reg;
    logic [DEG_W-1:0]          m_deg_reg;
    logic [DEG_W-1:0]          m_deg_next;

    logic                      advance;

    // one enable for every stage: move when the output word is free or taken
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    // ---- prepare stage: pick the half plane, fold y<0 by negating ----
    logic signed [IN_W-1:0]   in_x;
    logic signed [IN_W-1:0]   in_y;
    logic signed [COMP_W-1:0] in_x_ext;
    logic signed [COMP_W-1:0] in_y_ext;

    assign in_x     = s_tdata[IN_W-1:0];
    assign in_y     = s_tdata[2*IN_W-1:IN_W];
    assign in_x_ext = {{(COMP_W-IN_W){in_x[IN_W-1]}}, in_x};
    assign in_y_ext = {{(COMP_W-IN_W){in_y[IN_W-1]}}, in_y};

    always_comb begin
        z_next[0] = '0;
        priority if (in_y > 0) begin
            quad_next[0] = QUAD_Y_POS;
            x_next[0]    = in_y_ext;
            y_next[0]    = in_x_ext;
        end else if (in_y < 0) begin
            quad_next[0] = QUAD_Y_NEG;
            x_next[0]    = -in_y_ext;
            y_next[0]    = -in_x_ext;
        end else if (in_x < 0) begin
            quad_next[0] = QUAD_AXIS_NEG_X;
            x_next[0]    = '0;
            y_next[0]    = '0;
        end else begin
            quad_next[0] = QUAD_AXIS_POS_X;
            x_next[0]    = '0;
            y_next[0]    = '0;
        end
    end

    // ---- CORDIC vectoring, one iteration per stage ----
    for (genvar gi = 0; gi < STAGES; gi++) begin : g_iter
        logic signed [COMP_W-1:0]  xs;
        logic signed [COMP_W-1:0]  ys;
        logic signed [ANGLE_W-1:0] step;

        assign xs   = x_reg[gi] >>> gi;
        assign ys   = y_reg[gi] >>> gi;
        assign step = {{(ANGLE_W-ATAN_W){1'b0}}, ATAN_DEG_Q16[gi]};

        always_comb begin
            quad_next[gi+1] = quad_reg[gi];
            // residual exactly zero: no rotation, exact angles stay exact
            priority if (y_reg[gi] > 0) begin
                x_next[gi+1] = x_reg[gi] + ys;
                y_next[gi+1] = y_reg[gi] - xs;
                z_next[gi+1] = z_reg[gi] + step;
            end else if (y_reg[gi] < 0) begin
                x_next[gi+1] = x_reg[gi] - ys;
                y_next[gi+1] = y_reg[gi] + xs;
                z_next[gi+1] = z_reg[gi] - step;
            end else begin
                x_next[gi+1] = x_reg[gi];
                y_next[gi+1] = y_reg[gi];
                z_next[gi+1] = z_reg[gi];
            end
        end
    end

    // ---- output stage: heading from angle, clamp, truncate ----
    logic signed [HEAD_W-1:0] z_ext;
    logic signed [HEAD_W-1:0] head_q16;

    assign z_ext = {{(HEAD_W-ANGLE_W){z_reg[STAGES][ANGLE_W-1]}}, z_reg[STAGES]};

    always_comb begin
        unique case (quad_reg[STAGES])
            QUAD_Y_POS:      head_q16 = DEG90_Q16 - z_ext;
            QUAD_Y_NEG:      head_q16 = DEG270_Q16 - z_ext;
            QUAD_AXIS_NEG_X: head_q16 = DEG180_Q16;
            QUAD_AXIS_POS_X: head_q16 = '0;
            default:         head_q16 = '0;
        endcase
    end

    always_comb begin
        priority if (head_q16 < 0) begin
            m_deg_next = '0;
        end else if (head_q16 >= DEG360_Q16) begin
            m_deg_next = DEG_MAX;
        end else begin
            m_deg_next = head_q16[FRAC_BITS +: DEG_W];
        end
    end

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= STAGES; k++) begin
                valid_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg[0] <= s_tvalid;
            for (int k = 1; k <= STAGES; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
            m_valid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k <= STAGES; k++) begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                quad_reg[k] <= quad_next[k];
            end
            m_deg_reg <= m_deg_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-DEG_W){1'b0}}, m_deg_reg};

endmodule

FILE: hdl/chxy_checker.sv
// ----------------------------------------------------------------------------
// chxy_checker
// Port-level checks on the compass heading block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chxy_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [chxy_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [chxy_pkg::M_DATA_W-1:0] m_tdata
);
    import chxy_pkg::*;

    // a waiting input word holds its data until taken
    `ASSERT_CLK(a_in_stable, aclk, aresetn, (s_tvalid && !s_tready) |=> $stable(s_tdata))
    // a stalled output word stays up and unchanged
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid)
    `ASSERT_CLK(a_out_stable, aclk, aresetn, (m_tvalid && !m_tready) |=> $stable(m_tdata))
    // heading stays within a circle, padding bits zero
    `ASSERT_ALWAYS(a_deg_range, aclk, aresetn,
        !m_tvalid || ((m_tdata[DEG_W-1:0] <= DEG_MAX) && (m_tdata[M_DATA_W-1:DEG_W] == '0)))
    // the pipeline freezes as a whole: a stalled output blocks the input side
    `ASSERT_CLK(a_stall_backpressure, aclk, aresetn, (m_tvalid && !m_tready) |-> !s_tready)

endmodule

bind compass_heading_from_xy_top chxy_checker u_chxy_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pipelined CORDIC compass heading block.
// A fixed-point CORDIC model in the bench works out the heading for every
// X/Y word the block accepts. Each heading word that comes out is checked
// against the oldest pending prediction. The run covers directed corner
// points and then random samples of several shapes. Both stream sides idle
// at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    import chxy_pkg::*;

    localparam int  ITERATIONS   = 16;                 // CORDIC stages in the DUT
    localparam int  LATENCY      = ITERATIONS + 2;     // accept to m_tvalid
    localparam int  RANDOM_WORDS = 500;
    localparam int  CALM_WORDS   = 80;                 // tail run without idling
    localparam int  HOLD_CYCLES  = 120;                // long output hold-off
    localparam int  HOLD_AFTER   = 60;                 // words taken before hold-off
    localparam int  STALL_LIMIT  = 3000;               // cycles with no handshake
    localparam int  PRINT_CAP    = 50;

    // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
    localparam longint ATAN_STEP_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [8:0]         heading;
    } heading_due_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    // ------------------------------------------------------------------------
    // Heading predictor and in-order checker
    // ------------------------------------------------------------------------
    class heading_checker;
        heading_due_t headings_due[$];
        int           mismatches;
        int           words_taken;

        function new();
            mismatches  = 0;
            words_taken = 0;
        endfunction

        // atan(yv/xv) in Q16 degrees, xv >= 0, vectoring mode
        function longint cordic_angle(longint xv, longint yv);
            longint z;
            longint xs;
            longint ys;
            z = 0;
            for (int i = 0; i < ITERATIONS && i < 24; i++) begin
                xs = xv >>> i;
                ys = yv >>> i;
                if (yv > 0) begin
                    xv = xv + ys;
                    yv = yv - xs;
                    z  = z + ATAN_STEP_Q16[i];
                end else if (yv < 0) begin
                    xv = xv - ys;
                    yv = yv + xs;
                    z  = z - ATAN_STEP_Q16[i];
                end
            end
            return z;
        endfunction

        function logic [8:0] compass_heading(logic signed [15:0] x, logic signed [15:0] y);
            longint h;
            longint xl;
            longint yl;
            xl = longint'(x);
            yl = longint'(y);
            if (yl > 0)
                h = (longint'(90) << 16) - cordic_angle(yl, xl);
            else if (yl < 0)
                h = (longint'(270) << 16) - cordic_angle(-yl, -xl);   // flip into right half
            else if (xl < 0)
                h = longint'(180) << 16;
            else
                h = 0;
            if (h < 0)
                return 9'd0;
            if (h >= (longint'(360) << 16))
                return 9'd359;
            return 9'(h >>> 16);
        endfunction

        function void note_sample(logic signed [15:0] x, logic signed [15:0] y);
            heading_due_t d;
            d.x       = x;
            d.y       = y;
            d.heading = compass_heading(x, y);
            headings_due.push_back(d);
            words_taken++;
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_heading(logic [M_DATA_W-1:0] word);
            heading_due_t d;
            if (headings_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected heading word 0x%04h", word));
                return;
            end
            d = headings_due.pop_front();
            if (word[8:0] !== d.heading)
                flag_mismatch($sformatf("x=%0d y=%0d heading %0d, want %0d",
                                        d.x, d.y, word[8:0], d.heading));
            if (word[M_DATA_W-1:9] !== '0)
                flag_mismatch($sformatf("x=%0d y=%0d pad bits 0x%0h not zero",
                                        d.x, d.y, word[M_DATA_W-1:9]));
        endtask

        function int pending();
            return headings_due.size();
        endfunction
    endclass

    heading_checker board;
    bit             calm;        // tail phase: no idling on either side
    bit             long_hold;   // output side is in its long hold-off
    int             quiet_cycles;

    compass_heading_from_xy_top #(
        .ANGLE_ITERATIONS (ITERATIONS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [15:0] field_x, [31:16] field_y
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)      // [8:0] heading_deg, [15:9] zero
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Input side drivers; everything changes on the falling edge
    // ------------------------------------------------------------------------
    task send_word(logic signed [15:0] x, logic signed [15:0] y);
        s_tdata  <= {y, x};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(x, y);
        @(negedge aclk);
    endtask

    // random gap before the word, except in the tail and under the hold-off
    task offer(logic signed [15:0] x, logic signed [15:0] y);
        if (!calm && !long_hold && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        send_word(x, y);
    endtask

    task offer_random();
        logic signed [15:0] x;
        logic signed [15:0] y;
        int                 shape;
        x     = 16'($urandom);
        y     = 16'($urandom);
        shape = $urandom_range(0, 9);
        case (shape)
            0, 1: begin     // tiny vectors: axes, diagonals, coarse angles
                x = 16'($signed($urandom_range(0, 8)) - 4);
                y = 16'($signed($urandom_range(0, 8)) - 4);
            end
            2: begin        // on an axis
                if ($urandom_range(0, 1)) x = '0;
                else                      y = '0;
            end
            3: begin        // just off an axis: heading near a quadrant edge
                if ($urandom_range(0, 1)) x = 16'($signed($urandom_range(0, 6)) - 3);
                else                      y = 16'($signed($urandom_range(0, 6)) - 3);
            end
            4: begin        // full-scale components
                x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                if ($urandom_range(0, 1))
                    y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            5: begin        // diagonal, magnitudes equal
                x = 16'($urandom_range(1, 32767));
                y = $urandom_range(0, 1) ? x : -x;
                if ($urandom_range(0, 1)) x = -x;
            end
            default: ;      // full random
        endcase
        offer(x, y);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        bit held_once;
        held_once = 1'b0;
        m_tready  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held_once && board.words_taken >= HOLD_AFTER) begin
                long_hold = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold = 1'b0;
                held_once = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_heading(m_tdata);
    end

    // watchdog: no handshake on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        board        = new();
        calm         = 1'b0;
        long_hold    = 1'b0;
        quiet_cycles = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: origin and the four half-axes
        offer(16'sd0, 16'sd0);
        offer(16'sd1, 16'sd0);
        offer(-16'sd1, 16'sd0);
        offer(16'sh7fff, 16'sd0);
        offer(16'sh8000, 16'sd0);
        offer(16'sd0, 16'sd1);
        offer(16'sd0, -16'sd1);
        offer(16'sd0, 16'sh7fff);
        offer(16'sd0, 16'sh8000);
        // exact diagonals, where the residual hits zero early
        offer(16'sd1, 16'sd1);
        offer(-16'sd1, 16'sd1);
        offer(16'sd1, -16'sd1);
        offer(-16'sd1, -16'sd1);
        offer(16'sh7fff, 16'sh7fff);
        offer(16'sh8000, 16'sh8000);
        // full-scale corners of unequal magnitude
        offer(16'sh8000, 16'sh7fff);
        offer(16'sh7fff, 16'sh8000);
        // near-axis, one component tiny: headings close to an axis, incl. 0 / 360 and the clamps
        offer(16'sh7fff, 16'sd1);
        offer(16'sh8000, 16'sd1);
        offer(16'sh7fff, -16'sd1);
        offer(16'sh8000, -16'sd1);
        offer(16'sh8000, 16'sh8000 + 16'sd1);
        offer(16'sd1, 16'sh8000);
        offer(-16'sd1, 16'sh7fff);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            offer_random();
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);

        if (board.pending() != 0)
            board.flag_mismatch($sformatf("%0d headings never arrived", board.pending()));
        if (board.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/chxy_pkg.sv
hdl/compass_heading_from_xy_top.sv
hdl/chxy_checker.sv
verif/testbench.sv
